// ===== rtl/core/seeded_uniform_range_sampler_macros.svh =====
// Assertion macros shared by the sampler checker.
// Depends on nothing; included by the checker file only.
`ifndef SEEDED_UNIFORM_RANGE_SAMPLER_MACROS_SVH
`define SEEDED_UNIFORM_RANGE_SAMPLER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SURS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every edge, reset included.
`define SURS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/surs_pkg.sv =====
// Package for the seeded uniform range sampler: constants, types, mixer constants.
// No dependencies.
package surs_pkg;
  localparam logic [63:0] GoldenStep   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA      = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB      = 64'h94d049bb133111eb;
  localparam logic [63:0] SaltDisperse = 64'h5745504e2d444953;
  localparam logic [63:0] SaltRecoil   = 64'h5745504e2d524543;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [31:0] BoundReset   = 32'd3141592654;
  localparam logic [31:0] VersionReset = 32'd1;
  localparam logic [7:0]  LimitReset   = 8'd16;

  typedef enum logic [1:0] {
    CfgBound   = 2'd0,
    CfgVersion = 2'd1,
    CfgLimit   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRangeErr = 2'd1,
    StChanErr  = 2'd2
  } status_e;

  // Work item handed from the classifier to the draw engine.
  typedef struct packed {
    logic        draw;    // draws needed
    logic [63:0] state;   // unprimed generator state
    logic [33:0] span;    // hi - lo + 1
    logic [32:0] low;
    logic [32:0] sample;  // result when no draw is needed
    status_e     status;
  } job_t;
endpackage

// ===== rtl/core/surs_stream_if.sv =====
// Valid/ready channel carrying one payload type.
// Depends on nothing beyond the type parameter.
interface surs_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/surs_front.sv =====
// Front end: accepts requests, checks range and channel, builds a job.
// Depends on surs_pkg.
module surs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       bound_i,
  input  logic [31:0]       version_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [63:0]       seed_i,
  input  logic [1:0]        channel_i,
  input  logic [32:0]       range_low_i,
  input  logic [32:0]       range_high_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output surs_pkg::job_t    job_o
);
  logic               valid_q;
  surs_pkg::job_t     job_q, job_d;
  logic signed [33:0] lo, hi, bnd;

  assign lo  = {range_low_i[32], range_low_i};
  assign hi  = {range_high_i[32], range_high_i};
  assign bnd = {2'b00, bound_i};
  assign in_ready_o = !valid_q || job_ready_i;

  always_comb begin
    job_d        = '0;
    job_d.low    = range_low_i;
    job_d.span   = 34'(hi - lo + 34'sd1);
    job_d.state  = seed_i ^ (channel_i[0] ? surs_pkg::SaltRecoil : surs_pkg::SaltDisperse)
                   ^ {version_i, 32'd0};
    job_d.status = surs_pkg::StOk;
    if (lo < -bnd || hi > bnd || lo > hi) begin
      job_d.status = surs_pkg::StRangeErr;
    end else if (channel_i[1]) begin
      job_d.status = surs_pkg::StChanErr;
    end else if (lo == hi) begin
      job_d.sample = range_low_i;
    end else begin
      job_d.draw = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;
endmodule

// ===== rtl/core/surs_queue.sv =====
// Short job queue between the front end and the draw engine.
// Depends on surs_pkg.
module surs_queue #(
  parameter int unsigned Depth = surs_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  surs_pkg::job_t data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output surs_pkg::job_t data_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  surs_pkg::job_t     mem_q [Depth];
  logic [Aw-1:0]      wr_q, rd_q;
  logic [Aw:0]        cnt_q;

  assign full_o  = cnt_q == (Aw+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

// ===== rtl/core/surs_back.sv =====
// Draw engine: splitmix64 with a sequenced multiplier, serial 64-bit modulo.
// Depends on surs_pkg.
module surs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     limit_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  surs_pkg::job_t job_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [32:0]    sample_o,
  output logic [1:0]     status_o
);
  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SLimit = 10'b0000000010,
    SAdd   = 10'b0000000100,
    SMulA  = 10'b0000001000,
    SMulB  = 10'b0000010000,
    SFin   = 10'b0000100000,
    SCheck = 10'b0001000000,
    SMod   = 10'b0010000000,
    SOut   = 10'b0100000000,
    SHold  = 10'b1000000000
  } state_e;

  state_e       state_q, state_d;
  logic [63:0]  st_q, z_q, acc_q, lim_q, rem_q, quo_q;
  logic [33:0]  span_q;
  logic [32:0]  low_q, out_s_q, hold_s_q;
  logic [1:0]   out_st_q, hold_st_q;
  logic [7:0]   tries_q;
  logic [1:0]   part_q;     // 32-bit partial product counter
  logic [6:0]   bit_q;      // modulo bit counter
  logic         primed_q;   // first draw is discarded
  logic         limit_mode_q;
  logic         out_valid_q;
  logic [63:0]  mul_k;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  pp;
  logic [64:0]  trial;
  logic [63:0]  rem_sh;
  logic [63:0]  dividend;

  assign job_ready_o = state_q == SIdle;
  assign res_valid_o = out_valid_q;
  assign sample_o    = out_s_q;
  assign status_o    = out_st_q;

  // Multiplier: three 32x32 partial products, low 64 bits of z*k kept.
  assign mul_k = (state_q == SMulA) ? surs_pkg::MixMulA : surs_pkg::MixMulB;
  always_comb begin
    case (part_q)
      2'd0:    begin mul_a = z_q[31:0];  mul_b = mul_k[31:0];  end
      2'd1:    begin mul_a = z_q[63:32]; mul_b = mul_k[31:0];  end
      default: begin mul_a = z_q[31:0];  mul_b = mul_k[63:32]; end
    endcase
  end
  assign pp = mul_a * mul_b;

  // Restoring divider step: dividend bits fed MSB first from quo_q.
  assign dividend = quo_q;
  assign rem_sh   = {rem_q[62:0], dividend[63]};
  assign trial    = {rem_q, dividend[63]} - {31'd0, span_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == SHold && (!out_valid_q || res_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (job_valid_i) begin
            st_q     <= job_i.state;
            span_q   <= job_i.span;
            low_q    <= job_i.low;
            tries_q  <= '0;
            primed_q <= 1'b0;
            if (job_i.draw) begin
              quo_q        <= '1;
              rem_q        <= '0;
              bit_q        <= '0;
              limit_mode_q <= 1'b1;
              state_q      <= SLimit;
            end else begin
              hold_s_q  <= job_i.sample;
              hold_st_q <= job_i.status;
              state_q   <= SHold;
            end
          end
        end
        SLimit, SMod: begin
          // One quotient bit per cycle; only the remainder is needed.
          if (!trial[64]) rem_q <= trial[63:0];
          else            rem_q <= rem_sh;
          quo_q <= {quo_q[62:0], 1'b0};
          bit_q <= bit_q + 7'd1;
          if (bit_q == 7'd63) begin
            state_q <= (state_q == SLimit) ? SAdd : SOut;
          end
        end
        SAdd: begin
          if (limit_mode_q) begin
            lim_q        <= 64'hFFFF_FFFF_FFFF_FFFF - rem_q;
            limit_mode_q <= 1'b0;
          end
          st_q    <= st_q + surs_pkg::GoldenStep;
          z_q     <= (st_q + surs_pkg::GoldenStep)
                     ^ ((st_q + surs_pkg::GoldenStep) >> 30);
          part_q  <= '0;
          acc_q   <= '0;
          state_q <= SMulA;
        end
        SMulA, SMulB: begin
          if (part_q == 2'd0) acc_q <= pp;
          else                acc_q <= acc_q + {pp[31:0], 32'd0};
          part_q <= (part_q == 2'd2) ? 2'd0 : part_q + 2'd1;
          if (part_q == 2'd2) begin
            if (state_q == SMulA) begin
              z_q     <= (acc_q + {pp[31:0], 32'd0})
                         ^ ((acc_q + {pp[31:0], 32'd0}) >> 27);
              state_q <= SMulB;
            end else begin
              z_q     <= acc_q + {pp[31:0], 32'd0};
              state_q <= SFin;
            end
          end
        end
        SFin: begin
          z_q     <= z_q ^ (z_q >> 31);
          state_q <= SCheck;
        end
        SCheck: begin
          if (!primed_q) begin
            primed_q <= 1'b1;
            state_q  <= SAdd;
          end else if (z_q >= lim_q && (tries_q + 8'd1) < limit_i) begin
            tries_q <= tries_q + 8'd1;
            state_q <= SAdd;
          end else begin
            quo_q   <= z_q;
            rem_q   <= '0;
            bit_q   <= '0;
            state_q <= SMod;
          end
        end
        SOut: begin
          hold_s_q  <= 33'(low_q + rem_q[32:0]);
          hold_st_q <= surs_pkg::StOk;
          state_q   <= SHold;
        end
        SHold: begin
          // The finished result waits here until the output register is free.
          if (!out_valid_q || res_ready_i) begin
            out_s_q  <= hold_s_q;
            out_st_q <= hold_st_q;
            state_q  <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== rtl/core/seeded_uniform_range_sampler.sv =====
// Top level: config registers, front end, job queue and draw engine.
// Depends on surs_pkg, surs_stream_if, surs_front, surs_queue, surs_back.
//
// Channel   Dir  Payload
// in_if     in   seed, channel, range_low, range_high
// out_if    out  sample, status
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A draw request runs two 64-bit serial remainder passes (limit and result)
// plus one splitmix step per draw on the shared 32x32 multiplier, the
// discarded priming step included. Checked-only requests skip both.
// Reset is asynchronous; it clears control state and loads the config registers with their reset values.
// The queue lets the front end accept while the engine works or stalls.
module seeded_uniform_range_sampler #(
  parameter int unsigned QueueDepth = surs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  surs_stream_if.sink   in_if,
  surs_stream_if.source out_if
);
  logic [31:0]    bound_q, version_q;
  logic [7:0]     limit_q;
  logic           fj_valid, fj_ready, q_full, q_empty, b_ready;
  surs_pkg::job_t fj, qj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q   <= surs_pkg::BoundReset;
      version_q <= surs_pkg::VersionReset;
      limit_q   <= surs_pkg::LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        surs_pkg::CfgBound:   bound_q   <= cfg_data_i;
        surs_pkg::CfgVersion: version_q <= cfg_data_i;
        surs_pkg::CfgLimit:   limit_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  surs_front u_front (
    .clk_i, .rst_ni,
    .bound_i(bound_q), .version_i(version_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .seed_i(in_if.data.seed), .channel_i(in_if.data.channel),
    .range_low_i(in_if.data.range_low), .range_high_i(in_if.data.range_high),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  assign fj_ready = !q_full;

  surs_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(fj_valid && !q_full), .full_o(q_full), .data_i(fj),
    .pop_i(!q_empty && b_ready), .empty_o(q_empty), .data_o(qj)
  );

  surs_back u_back (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .job_valid_i(!q_empty), .job_ready_o(b_ready), .job_i(qj),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready),
    .sample_o(out_if.data.sample), .status_o(out_if.data.status)
  );
endmodule

// ===== rtl/core/surs_checker.sv =====
// Port-level checker for the sampler, bound to the top level.
// Depends on the macros header and surs_pkg.
`include "seeded_uniform_range_sampler_macros.svh"
module surs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] sample,
  input logic [1:0]  status
);
  `SURS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(sample), "result dropped while stalled")
  `SURS_ASSERT(a_err_zero, clk_i, rst_ni, out_valid && status != surs_pkg::StOk |-> sample == 33'd0, "error result not zero")
  `SURS_ASSERT(a_status, clk_i, rst_ni, out_valid |-> (status == surs_pkg::StOk || status == surs_pkg::StRangeErr || status == surs_pkg::StChanErr), "bad status code")
  `SURS_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |-> !out_valid, "result valid in reset")
endmodule

bind seeded_uniform_range_sampler surs_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .sample(out_if.data.sample), .status(out_if.data.status)
);
